// ----- hw/rtl/cpc_pkg.sv -----
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants for the clipped pixel compositor
// Item structs, configuration layout, register indexes and draw modes.
// ----------------------------------------------------------------------------
package cpc_pkg;

  // Framebuffer size limits for clipping
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam logic [12:0] X_LIMIT = 13'(MAX_WIDTH);
  localparam logic [12:0] Y_LIMIT = 13'(MAX_HEIGHT);

  localparam logic [7:0] TRANSPARENT_PIXEL = 8'hFF;
  localparam logic [7:0] MAX_COLOR_UNIT    = 8'd31;

  localparam int TABLE_DEPTH = 65536;
  localparam int TABLE_AW    = 16;
  localparam int CFG_DW      = 11;

  typedef enum logic [2:0] {
    REG_WIN_MIN_X   = 3'd0,
    REG_WIN_MIN_Y   = 3'd1,
    REG_WIN_MAX_X   = 3'd2,
    REG_WIN_MAX_Y   = 3'd3,
    REG_SCREEN_W    = 3'd4,
    REG_DRAW_MODE   = 3'd5,
    REG_FILL_COLOR  = 3'd6,
    REG_BLEND_LIMIT = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MODE_COPY       = 3'd0,
    MODE_BLEND      = 3'd1,
    MODE_SHADE      = 3'd2,
    MODE_BLEND_FILL = 3'd3,
    MODE_SOLID_FILL = 3'd4
  } draw_mode_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_DRAW = 1'b1
  } command_t;

  typedef struct packed {
    logic [9:0]  win_min_x;
    logic [9:0]  win_min_y;
    logic [9:0]  win_max_x;
    logic [9:0]  win_max_y;
    logic [10:0] screen_width;
    logic [2:0]  draw_mode;
    logic [7:0]  fill_color;
    logic [8:0]  blend_limit;
  } cfg_t;

  typedef struct packed {
    logic               command;
    logic [15:0]        table_index;
    logic [7:0]         table_value;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [7:0]         src_pixel;
    logic [7:0]         dst_pixel;
  } in_item_t;

  typedef struct packed {
    logic        write_enable;
    logic [19:0] address;
    logic [7:0]  pixel_out;
  } out_item_t;

  // Decoded draw item, held between the front and back stages
  typedef struct packed {
    logic       we;
    logic       addr_en;
    logic       use_table;
    logic [7:0] pix_direct;
    logic [9:0] x;
    logic [9:0] y;
  } front_t;

endpackage

// ----- hw/rtl/cpc_ram.sv -----
// ----------------------------------------------------------------------------
// cpc_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/cpc_cfg.sv -----
// ----------------------------------------------------------------------------
// cpc_cfg: configuration register file
// Window, screen width, mode, fill color and blend limit registers.
// ----------------------------------------------------------------------------
module cpc_cfg
  import cpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [CFG_DW-1:0] wr_data,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_WIN_MIN_X:   cfg_nxt.win_min_x    = wr_data[9:0];
        REG_WIN_MIN_Y:   cfg_nxt.win_min_y    = wr_data[9:0];
        REG_WIN_MAX_X:   cfg_nxt.win_max_x    = wr_data[9:0];
        REG_WIN_MAX_Y:   cfg_nxt.win_max_y    = wr_data[9:0];
        REG_SCREEN_W:    cfg_nxt.screen_width = wr_data[10:0];
        REG_DRAW_MODE:   cfg_nxt.draw_mode    = wr_data[2:0];
        REG_FILL_COLOR:  cfg_nxt.fill_color   = wr_data[7:0];
        REG_BLEND_LIMIT: cfg_nxt.blend_limit  = wr_data[8:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.win_min_x    <= 10'd0;
      cfg_r.win_min_y    <= 10'd0;
      cfg_r.win_max_x    <= 10'd639;
      cfg_r.win_max_y    <= 10'd479;
      cfg_r.screen_width <= 11'd640;
      cfg_r.draw_mode    <= MODE_COPY;
      cfg_r.fill_color   <= 8'd0;
      cfg_r.blend_limit  <= 9'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/cpc_front.sv -----
// ----------------------------------------------------------------------------
// cpc_front: clipping, mode decode and blend table address
// Decides visibility, the direct pixel value and whether the table is read.
// ----------------------------------------------------------------------------
module cpc_front
  import cpc_pkg::*;
(
  input  in_item_t              item,
  input  cfg_t                  cfg,
  output front_t                dec,
  output logic                  tbl_rd,
  output logic [TABLE_AW-1:0]   tbl_addr
);

  logic       x_in, y_in, visible;
  logic [7:0] shade_c;
  logic       draw;

  // Negative positions fail every lower bound, so test the sign first
  assign x_in = !item.pos_x[11]
             && ({1'b0, item.pos_x[10:0]} >= {2'b0, cfg.win_min_x})
             && ({1'b0, item.pos_x[10:0]} <= {2'b0, cfg.win_max_x})
             && ({2'b0, item.pos_x[10:0]} <  X_LIMIT);
  assign y_in = !item.pos_y[11]
             && ({1'b0, item.pos_y[10:0]} >= {2'b0, cfg.win_min_y})
             && ({1'b0, item.pos_y[10:0]} <= {2'b0, cfg.win_max_y})
             && ({2'b0, item.pos_y[10:0]} <  Y_LIMIT);

  assign draw    = (item.command == CMD_DRAW);
  assign visible = draw && x_in && y_in;

  // Low sprite values are recolored with the fill color
  assign shade_c = (item.src_pixel <= MAX_COLOR_UNIT) ? cfg.fill_color : item.src_pixel;

  always_comb begin
    dec            = '0;
    dec.x          = item.pos_x[9:0];
    dec.y          = item.pos_y[9:0];
    tbl_addr       = {item.dst_pixel, item.src_pixel};
    if (visible) begin
      dec.addr_en = 1'b1;
      unique case (cfg.draw_mode)
        MODE_COPY: begin
          dec.we         = 1'b1;
          dec.pix_direct = item.src_pixel;
        end
        MODE_BLEND: begin
          dec.we        = 1'b1;
          dec.use_table = 1'b1;
        end
        MODE_SHADE: begin
          if (item.src_pixel != TRANSPARENT_PIXEL) begin
            dec.we = 1'b1;
            if ({1'b0, shade_c} < cfg.blend_limit) begin
              dec.use_table = 1'b1;
              tbl_addr      = {item.dst_pixel, shade_c};
            end else begin
              dec.pix_direct = shade_c;
            end
          end
        end
        MODE_BLEND_FILL: begin
          dec.we        = 1'b1;
          dec.use_table = 1'b1;
          tbl_addr      = {cfg.fill_color, item.dst_pixel};
        end
        MODE_SOLID_FILL: begin
          dec.we         = 1'b1;
          dec.pix_direct = cfg.fill_color;
        end
        default: begin
          dec.we = 1'b0;
        end
      endcase
    end
  end

  assign tbl_rd = dec.use_table;

endmodule

// ----- hw/rtl/cpc_back.sv -----
// ----------------------------------------------------------------------------
// cpc_back: address generation and final pixel select
// Address is row times screen width plus column, wrapped to 20 bits.
// ----------------------------------------------------------------------------
module cpc_back
  import cpc_pkg::*;
(
  input  front_t      dec,
  input  logic [7:0]  tbl_data,
  input  logic [10:0] screen_width,
  output out_item_t   result
);

  logic [20:0] row_base;
  logic [19:0] addr;

  assign row_base = {11'b0, dec.y} * {10'b0, screen_width};
  assign addr     = row_base[19:0] + {10'b0, dec.x};

  always_comb begin
    result.write_enable = dec.we;
    result.address      = dec.addr_en ? addr : 20'd0;
    result.pixel_out    = dec.use_table ? tbl_data : dec.pix_direct;
  end

endmodule

// ----- hw/rtl/clipped_pixel_compositor.sv -----
// ----------------------------------------------------------------------------
// clipped_pixel_compositor: 8-bit indexed color raster operation unit
// Pipeline: an input transfer reaches out_valid through the decode and table
//   read stage, then address multiply and pixel select into the output reg.
// Throughput: one item per cycle unless out_stall backs up, set by the single blend table read port.
// Reset (rst_n low, synchronous): pipeline empty, config regs at defaults;
//   the blend table is not cleared and has no clearing pass.
// ----------------------------------------------------------------------------
module clipped_pixel_compositor
  import cpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // pixel / table load input
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  // framebuffer write result
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  cfg_t                cfg;
  front_t              dec;
  logic                tbl_rd;
  logic [TABLE_AW-1:0] tbl_addr;
  logic [7:0]          tbl_data;
  out_item_t           result;

  logic      in_accept;
  logic      s1_load, s2_load;
  logic      ram_we, ram_re;

  logic      s1_valid_r, s1_valid_nxt;
  front_t    s1_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r;

  // Config writes are always taken; software is to make writes only while idle, which the block does not enforce.
  assign cfg_ready = 1'b1;

  cpc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Stage 0: clip and decode straight off the input channel
  cpc_front u_front (
    .item     (in_data),
    .cfg      (cfg),
    .dec      (dec),
    .tbl_rd   (tbl_rd),
    .tbl_addr (tbl_addr)
  );

  // Pipeline control. The output register loads when empty or being
  // drained; stage 1 moves whenever the output register can take it.
  // So a new input transfer is taken while a result waits, as long as
  // stage 1 is free.
  assign s2_load   = !out_valid_r || !out_stall;
  assign s1_load   = !s1_valid_r || s2_load;
  assign in_stall  = !s1_load;
  assign in_accept = in_valid && !in_stall;

  // Table loads write, draws that need a blend read. Never both for one
  // item, so one RAM with a write and a read port is enough. A read only
  // happens on an input transfer, so the read data holds while stage 1
  // is stalled.
  assign ram_we = in_accept && (in_data.command == CMD_LOAD);
  assign ram_re = in_accept && tbl_rd;

  cpc_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.table_index),
    .wdata (in_data.table_value),
    .re    (ram_re),
    .raddr (tbl_addr),
    .rdata (tbl_data)
  );

  assign s1_valid_nxt  = s1_load ? in_accept : s1_valid_r;
  assign out_valid_nxt = s2_load ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= dec;
    end
    if (s2_load) begin
      out_r <= result;
    end
  end

  // Stage 1: address multiply and table/direct pixel select
  cpc_back u_back (
    .dec          (s1_r),
    .tbl_data     (tbl_data),
    .screen_width (cfg.screen_width),
    .result       (result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // A table read must land on a stage 1 item that uses it
  a_read_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> (s1_valid_r && s1_r.use_table))
    else $error("table read without a matching stage 1 item");

  // Stage 1 holds its item while the output side is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_load) |=> (s1_valid_r && $stable(s1_r)))
    else $error("stage 1 item lost under backpressure");

  // No-write results always carry a zero pixel
  a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.write_enable) |-> (out_r.pixel_out == 8'd0))
    else $error("nonzero pixel on a no-write result");

endmodule
